FILE: src/tekd_pkg.sv
`default_nettype none

package tekd_pkg;

   localparam int MaxSeqLen = 4;
   localparam int NumKeys = 9;
   localparam int KeyBytes = 4;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic [15:0] TimeoutReset = 16'd100;
   localparam logic [15:0] ElapsedMax = 16'hFFFF;

   localparam logic [7:0] EscByte = 8'h1B;
   localparam logic [7:0] AltOpenByte = 8'hC3;
   localparam logic [7:0] NullByte = 8'h00;

   // Register index, taken from paddr[2]
   localparam logic RegTimeout = 1'b0;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_BYTE = 2'd1,
      KIND_KEY  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]            len;
      logic [0:3][7:0]       bytes;
   } key_pattern_type;

   // Index in this table is the key code
   localparam key_pattern_type KeyPatterns [NumKeys] = '{
      '{len: 3'd3, bytes: {EscByte, 8'h5B, 8'h43, NullByte}},  // right
      '{len: 3'd3, bytes: {EscByte, 8'h5B, 8'h44, NullByte}},  // left
      '{len: 3'd3, bytes: {EscByte, 8'h5B, 8'h41, NullByte}},  // cancel (up)
      '{len: 3'd4, bytes: {EscByte, 8'h5B, 8'h31, 8'h7E}},     // home
      '{len: 3'd4, bytes: {EscByte, 8'h5B, 8'h32, 8'h7E}},     // insert
      '{len: 3'd4, bytes: {EscByte, 8'h5B, 8'h33, 8'h7E}},     // delete
      '{len: 3'd4, bytes: {EscByte, 8'h5B, 8'h34, 8'h7E}},     // end
      '{len: 3'd3, bytes: {EscByte, 8'h4F, 8'h44, NullByte}},  // ctrl-left
      '{len: 3'd3, bytes: {EscByte, 8'h4F, 8'h43, NullByte}}   // ctrl-right
   };

endpackage

`default_nettype wire

FILE: src/tekd_if.sv
`default_nettype none

interface tekd_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface tekd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

FILE: src/tekd_csr.sv
`default_nettype none

module tekd_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [tekd_pkg::CsrAddrW-1:0] paddr,
   input  wire logic [tekd_pkg::CsrDataW-1:0] pwdata,
   output logic      [tekd_pkg::CsrDataW-1:0] prdata,
   output logic                               pready,
   output logic      [15:0]                   timeout_ticks
);

   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == tekd_pkg::RegTimeout);

   always_comb begin
      timeout_in = timeout_ff;
      if (wr_hit) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= tekd_pkg::TimeoutReset;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == tekd_pkg::RegTimeout) begin
         prdata = {{(tekd_pkg::CsrDataW-16){1'b0}}, timeout_ff};
      end
   end

   assign timeout_ticks = timeout_ff;

endmodule

`default_nettype wire

FILE: src/tekd_rsp_queue.sv
`default_nettype none

module tekd_rsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire tekd_pkg::rsp_word_type push_word,
   output logic                        full,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output tekd_pkg::rsp_word_type      out_word
);

   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   tekd_pkg::rsp_word_type slot0_ff;
   tekd_pkg::rsp_word_type slot0_in;
   tekd_pkg::rsp_word_type slot1_ff;
   tekd_pkg::rsp_word_type slot1_in;
   logic                   pop;
   logic [1:0]             wr_idx;

   assign out_valid = (count_ff != 2'd0);
   assign full = (count_ff == 2'd2);
   assign out_word = slot0_ff;
   assign pop = out_valid && out_ready;
   assign wr_idx = count_ff - {1'b0, pop};

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      // advance the head
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (wr_idx == 2'd0) begin
            slot0_in = push_word;
         end else begin
            slot1_in = push_word;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

FILE: src/tekd_core.sv
`default_nettype none

module tekd_core #(
   parameter int MAX_SEQ_LEN = tekd_pkg::MaxSeqLen
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [15:0]            timeout_ticks,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic                   in_op,
   input  wire logic [7:0]             in_byte,
   input  wire logic                   queue_full,
   output logic                        push,
   output tekd_pkg::rsp_word_type      push_word
);

   localparam int CntW = $clog2(MAX_SEQ_LEN + 1);
   localparam int IdxW = $clog2(MAX_SEQ_LEN);

   logic                in_escape_ff;
   logic                in_escape_in;
   logic [CntW-1:0]     seq_count_ff;
   logic [CntW-1:0]     seq_count_in;
   logic [15:0]         esc_elapsed_ff;
   logic [15:0]         esc_elapsed_in;
   logic [7:0]          seq_bytes_ff [MAX_SEQ_LEN];
   logic                wr_en;
   logic [IdxW-1:0]     wr_idx;

   logic                accept;
   logic [0:3][7:0]     view;
   logic [CntW-1:0]     count_next;
   logic                hit;
   logic [7:0]          hit_code;
   logic                pat_ok;

   assign in_ready = !queue_full;
   assign accept = in_valid && in_ready;
   assign push = accept;
   assign wr_idx = seq_count_ff[IdxW-1:0];
   assign count_next = seq_count_ff + CntW'(1);

   // collected bytes as they stand once the offered byte is appended
   always_comb begin
      for (int j = 0; j < tekd_pkg::KeyBytes; j++) begin
         view[j] = (seq_count_ff == CntW'(j)) ? in_byte : seq_bytes_ff[IdxW'(j)];
      end
   end

   // lowest matching key code wins
   always_comb begin
      hit = 1'b0;
      hit_code = '0;
      for (int k = tekd_pkg::NumKeys - 1; k >= 0; k--) begin
         pat_ok = (CntW'(tekd_pkg::KeyPatterns[k].len) == count_next);
         for (int j = 0; j < tekd_pkg::KeyBytes; j++) begin
            if ((j < int'(tekd_pkg::KeyPatterns[k].len)) &&
                (view[j] != tekd_pkg::KeyPatterns[k].bytes[j])) begin
               pat_ok = 1'b0;
            end
         end
         if (pat_ok) begin
            hit = 1'b1;
            hit_code = 8'(k);
         end
      end
   end

   always_comb begin
      in_escape_in = in_escape_ff;
      seq_count_in = seq_count_ff;
      esc_elapsed_in = esc_elapsed_ff;
      wr_en = 1'b0;
      push_word.kind = tekd_pkg::KIND_NONE;
      push_word.value = '0;
      if (accept) begin
         if (in_op == tekd_pkg::OP_TICK) begin
            if (in_escape_ff && (esc_elapsed_ff != tekd_pkg::ElapsedMax)) begin
               esc_elapsed_in = esc_elapsed_ff + 16'd1;
            end
         end else if (in_escape_ff) begin
            if ((esc_elapsed_ff >= timeout_ticks) ||
                (seq_count_ff >= CntW'(MAX_SEQ_LEN))) begin
               // abandon: emit the opening byte, drop this one
               push_word.kind = tekd_pkg::KIND_BYTE;
               push_word.value = seq_bytes_ff[0];
               in_escape_in = 1'b0;
               seq_count_in = '0;
               esc_elapsed_in = '0;
            end else if (in_byte != tekd_pkg::NullByte) begin
               wr_en = 1'b1;
               seq_count_in = count_next;
               if (hit) begin
                  push_word.kind = tekd_pkg::KIND_KEY;
                  push_word.value = hit_code;
                  in_escape_in = 1'b0;
                  seq_count_in = '0;
                  esc_elapsed_in = '0;
               end
            end
         end else if ((in_byte == tekd_pkg::EscByte) ||
                      (in_byte == tekd_pkg::AltOpenByte)) begin
            // count is zero while closed, so this lands in entry 0
            wr_en = 1'b1;
            in_escape_in = 1'b1;
            seq_count_in = CntW'(1);
            esc_elapsed_in = '0;
         end else if (in_byte != tekd_pkg::NullByte) begin
            push_word.kind = tekd_pkg::KIND_BYTE;
            push_word.value = in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_escape_ff <= 1'b0;
         seq_count_ff <= '0;
         esc_elapsed_ff <= '0;
      end else begin
         in_escape_ff <= in_escape_in;
         seq_count_ff <= seq_count_in;
         esc_elapsed_ff <= esc_elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_bytes_ff[wr_idx] <= in_byte;
      end
   end

endmodule

`default_nettype wire

FILE: src/terminal_escape_key_decoder.sv
`default_nettype none

// Terminal escape key decoder. Each word on req carries either a received byte
// (op 0) or a timer tick (op 1), and every accepted word yields exactly one word
// on rsp: kind 0 for nothing, kind 1 for a plain byte, kind 2 for a key code
// (0 right, 1 left, 2 cancel, 3 home, 4 insert, 5 delete, 6 end, 7 ctrl-left,
// 8 ctrl-right). ESC or 0xC3 opens a sequence of up to MAX_SEQ_LEN bytes that
// is compared against all keys in parallel; on timeout or a full buffer the
// opening byte comes out raw and the offered byte is dropped. One word is
// accepted per clock while the result queue is not full: the decode is
// combinational on the sequence state, and a two-word result queue keeps req
// ready while one result waits on rsp. The timeout register (ticks, reset 100)
// sits at APB address 0 and the user must see it written only while idle.

module terminal_escape_key_decoder #(
   parameter int MAX_SEQ_LEN = tekd_pkg::MaxSeqLen
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tekd_req_if.sink                           req,
   tekd_rsp_if.source                         rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [tekd_pkg::CsrAddrW-1:0] paddr,
   input  wire logic [tekd_pkg::CsrDataW-1:0] pwdata,
   output logic      [tekd_pkg::CsrDataW-1:0] prdata,
   output logic                               pready
);

   logic [15:0]            timeout_ticks;
   logic                   queue_full;
   logic                   push;
   tekd_pkg::rsp_word_type push_word;
   tekd_pkg::rsp_word_type head_word;

   tekd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .timeout_ticks (timeout_ticks)
   );

   tekd_core #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .timeout_ticks (timeout_ticks),
      .in_valid      (req.valid),
      .in_ready      (req.ready),
      .in_op         (req.op),
      .in_byte       (req.rx_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_word     (push_word)
   );

   tekd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_word  (head_word)
   );

   assign rsp.kind = head_word.kind;
   assign rsp.value = head_word.value;

endmodule

`default_nettype wire

FILE: bench/key_decode_monitor.sv
`default_nettype none

module key_decode_monitor
   import tekd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   tekd_req_if                      req,
   tekd_rsp_if                      rsp,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CsrAddrW-1:0] paddr,
   input  wire logic [CsrDataW-1:0] pwdata,
   input  wire logic                pready,
   output int                       errors,
   output int                       awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] KeyRight     = 8'd0;
   localparam logic [7:0] KeyLeft      = 8'd1;
   localparam logic [7:0] KeyCancel    = 8'd2;
   localparam logic [7:0] KeyHome      = 8'd3;
   localparam logic [7:0] KeyInsert    = 8'd4;
   localparam logic [7:0] KeyDelete    = 8'd5;
   localparam logic [7:0] KeyEnd       = 8'd6;
   localparam logic [7:0] KeyCtrlLeft  = 8'd7;
   localparam logic [7:0] KeyCtrlRight = 8'd8;

   localparam logic [7:0] ChBracket = 8'h5B;
   localparam logic [7:0] ChUpperO  = 8'h4F;
   localparam logic [7:0] ChUpperA  = 8'h41;
   localparam logic [7:0] ChUpperC  = 8'h43;
   localparam logic [7:0] ChUpperD  = 8'h44;
   localparam logic [7:0] ChOne     = 8'h31;
   localparam logic [7:0] ChTwo     = 8'h32;
   localparam logic [7:0] ChThree   = 8'h33;
   localparam logic [7:0] ChFour    = 8'h34;
   localparam logic [7:0] ChTilde   = 8'h7E;

   logic        in_seq;
   logic [2:0]  seq_len;
   logic [7:0]  seq_buf [MaxSeqLen];
   logic [15:0] elapsed;
   logic [15:0] timeout_ticks;

   rsp_word_type decoded_due [$];

   function automatic void close_seq();
      in_seq = 1'b0;
      seq_len = '0;
      elapsed = '0;
   endfunction

   // Only the entries below seq_len are looked at, so unwritten slots never matter.
   function automatic bit lookup_key(output logic [7:0] code);
      bit found;
      found = 1'b0;
      code = '0;
      if (seq_len == 3 && seq_buf[0] == EscByte) begin
         found = 1'b1;
         case ({seq_buf[1], seq_buf[2]})
            {ChBracket, ChUpperC}: code = KeyRight;
            {ChBracket, ChUpperD}: code = KeyLeft;
            {ChBracket, ChUpperA}: code = KeyCancel;
            {ChUpperO, ChUpperD}:  code = KeyCtrlLeft;
            {ChUpperO, ChUpperC}:  code = KeyCtrlRight;
            default:               found = 1'b0;
         endcase
      end else if (seq_len == 4 && seq_buf[0] == EscByte && seq_buf[1] == ChBracket
                   && seq_buf[3] == ChTilde) begin
         found = 1'b1;
         case (seq_buf[2])
            ChOne:   code = KeyHome;
            ChTwo:   code = KeyInsert;
            ChThree: code = KeyDelete;
            ChFour:  code = KeyEnd;
            default: found = 1'b0;
         endcase
      end
      return found;
   endfunction

   function automatic rsp_word_type decode_step(input op_type op, input logic [7:0] c);
      rsp_word_type w;
      logic [7:0] code;
      w.kind = KIND_NONE;
      w.value = '0;
      if (op == OP_TICK) begin
         if (in_seq && elapsed != ElapsedMax) elapsed++;
      end else if (in_seq) begin
         if (elapsed >= timeout_ticks || seq_len >= MaxSeqLen) begin
            // abandon: opening byte comes out raw, offered byte is lost
            w.kind = KIND_BYTE;
            w.value = seq_buf[0];
            close_seq();
         end else if (c != NullByte) begin
            seq_buf[seq_len] = c;
            seq_len++;
            if (lookup_key(code)) begin
               w.kind = KIND_KEY;
               w.value = code;
               close_seq();
            end
         end
      end else if (c == EscByte || c == AltOpenByte) begin
         in_seq = 1'b1;
         seq_buf[0] = c;
         seq_len = 3'd1;
         elapsed = '0;
      end else if (c != NullByte) begin
         w.kind = KIND_BYTE;
         w.value = c;
      end
      return w;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type seen;
      rsp_word_type due;
      if (reset) begin
         close_seq();
         timeout_ticks = TimeoutReset;
         decoded_due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == RegTimeout)
            timeout_ticks = pwdata[15:0];
         if (req.valid && req.ready)
            decoded_due.push_back(decode_step(op_type'(req.op), req.rx_byte));
         if (rsp.valid && rsp.ready) begin
            seen.kind = kind_type'(rsp.kind);
            seen.value = rsp.value;
            if (decoded_due.size() == 0) begin
               errors++;
               $display("%0t: rsp word with nothing due: expected none, got kind %0d value 0x%02h",
                        $time, seen.kind, seen.value);
            end else begin
               due = decoded_due.pop_front();
               if (seen.kind != due.kind || seen.value != due.value) begin
                  errors++;
                  $display("%0t: rsp mismatch: expected kind %0d value 0x%02h,",
                           $time, due.kind, due.value);
                  $display("%0t:    got kind %0d value 0x%02h",
                           $time, seen.kind, seen.value);
               end
            end
         end
      end
      awaited = decoded_due.size();
   end

endmodule

`default_nettype wire

FILE: bench/terminal_escape_key_decoder_test.sv
`default_nettype none

module terminal_escape_key_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tekd_pkg::*;

   localparam int CycleLimit  = 1_000_000;
   localparam int RandomWords = 1950;
   localparam int NumPhases   = 8;

   localparam logic [7:0] ChBracket = 8'h5B;
   localparam logic [7:0] ChUpperO  = 8'h4F;
   localparam logic [7:0] ChUpperA  = 8'h41;
   localparam logic [7:0] ChUpperC  = 8'h43;
   localparam logic [7:0] ChUpperD  = 8'h44;
   localparam logic [7:0] ChOne     = 8'h31;
   localparam logic [7:0] ChThree   = 8'h33;
   localparam logic [7:0] ChTilde   = 8'h7E;

   // Byte strings of the nine keys, left aligned
   localparam logic [31:0] KeyStrokes [NumKeys] = '{
      {EscByte, ChBracket, ChUpperC, NullByte},
      {EscByte, ChBracket, ChUpperD, NullByte},
      {EscByte, ChBracket, ChUpperA, NullByte},
      {EscByte, ChBracket, 8'h31, ChTilde},
      {EscByte, ChBracket, 8'h32, ChTilde},
      {EscByte, ChBracket, 8'h33, ChTilde},
      {EscByte, ChBracket, 8'h34, ChTilde},
      {EscByte, ChUpperO, ChUpperD, NullByte},
      {EscByte, ChUpperO, ChUpperC, NullByte}
   };
   localparam int StrokeLen [NumKeys] = '{3, 3, 3, 4, 4, 4, 4, 3, 3};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [CsrDataW-1:0] pwdata = '0;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   bit          steady;
   int          words_sent;
   int          fail_count;
   int          awaited;
   int          cycles;
   logic [15:0] timeout_now = TimeoutReset;

   tekd_req_if req_ch ();
   tekd_rsp_if rsp_ch ();

   terminal_escape_key_decoder uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   key_decode_monitor monitor (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .pready  (pready),
      .errors  (fail_count),
      .awaited (awaited)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("terminal_escape_key_decoder_test: errors");
         $finish;
      end
   end

   initial begin : rsp_drain
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 8);
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   task automatic push_word(input op_type op, input logic [7:0] b);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         req_ch.op <= 1'($urandom_range(0, 1));
         req_ch.rx_byte <= 8'($urandom_range(0, 255));
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      words_sent++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_word(OP_BYTE, b);
   endtask

   task automatic push_tick();
      push_word(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Drop valid and hold off until every due word has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] ticks);
      hold_until_drained();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {RegTimeout, 2'b00};
      pwdata <= {16'($urandom_range(0, 65535)), ticks};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      timeout_now = ticks;
   endtask

   function automatic logic [7:0] near_miss_byte();
      case ($urandom_range(0, 6))
         0: return ChBracket;
         1: return ChUpperO;
         2: return 8'(ChUpperA + $urandom_range(0, 3));
         3: return 8'(ChOne + $urandom_range(0, 3));
         4: return ChTilde;
         5: return ($urandom_range(0, 1) == 0) ? EscByte : AltOpenByte;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_group();
      int pick;
      int n;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // well-formed key, now and then with a zero byte or tick inside
         k = $urandom_range(0, NumKeys - 1);
         for (int i = 0; i < StrokeLen[k]; i++) begin
            if (i > 0 && $urandom_range(0, 5) == 0) begin
               if ($urandom_range(0, 1) == 0) push_tick();
               else push_byte(NullByte);
            end
            push_byte(KeyStrokes[k][31 - 8*i -: 8]);
         end
      end else if (pick < 60) begin
         push_byte(($urandom_range(0, 2) == 0) ? AltOpenByte : EscByte);
         n = $urandom_range(0, 5);
         repeat (n) push_byte(near_miss_byte());
      end else if (pick < 75) begin
         // open, then tick up to around the timeout when it is short
         push_byte(($urandom_range(0, 3) == 0) ? AltOpenByte : EscByte);
         n = $urandom_range(0, 2);
         repeat (n) push_byte(near_miss_byte());
         n = (timeout_now <= 400) ? $urandom_range(0, timeout_now + 2) : $urandom_range(0, 5);
         repeat (n) push_tick();
         push_byte(($urandom_range(0, 3) == 0) ? NullByte : near_miss_byte());
      end else if (pick < 92) begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 3);
         repeat (n) push_tick();
      end
   endtask

   initial begin : stimulus
      logic [15:0] phase_timeouts [NumPhases] = '{16'd100, 16'd0, 16'd1, 16'd2, 16'd6,
                                                  16'd25, 16'hFFFF, 16'd300};
      int goal;
      req_ch.valid = 1'b0;
      req_ch.op = 1'b0;
      req_ch.rx_byte = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain bytes, zero byte, tick outside a sequence
      push_byte(8'h01);
      push_byte(8'hFF);
      push_byte(NullByte);
      push_tick();
      push_byte(8'h80);
      // a few keys, one with a tick inside
      push_byte(EscByte); push_byte(ChBracket); push_byte(ChUpperC);
      push_byte(EscByte); push_tick(); push_byte(ChUpperO); push_byte(ChUpperD);
      push_byte(EscByte); push_byte(ChBracket); push_byte(ChThree); push_byte(ChTilde);
      // 0xC3 opener never matches: full buffer abandons it
      push_byte(AltOpenByte); push_byte(ChUpperA); push_byte(8'h42); push_byte(ChUpperC);
      push_byte(ChUpperD);
      // zero byte inside, second ESC collected, then full buffer
      push_byte(EscByte); push_byte(NullByte); push_byte(EscByte); push_byte(ChBracket);
      push_byte(ChUpperA); push_byte(ChTilde);

      // shortest timeouts
      write_timeout(16'd1);
      push_byte(EscByte); push_tick(); push_byte(ChUpperD);
      write_timeout(16'd0);
      push_byte(EscByte); push_byte(NullByte);

      foreach (phase_timeouts[p]) begin
         write_timeout(phase_timeouts[p]);
         steady = 1'b0;
         goal = words_sent + RandomWords / NumPhases;
         while (words_sent < goal) begin
            if ($urandom_range(0, 49) == 0) steady = ~steady;
            if ($urandom_range(0, 199) == 0) hold_until_drained();
            random_group();
         end
      end

      steady = 1'b0;
      hold_until_drained();
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("terminal_escape_key_decoder_test: clean");
      end else begin
         $display("terminal_escape_key_decoder_test: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
